### design/m65_pkg.sv
// ----------------------------------------------------------------------------
// m65_pkg
// Shared types, operation codes and flag positions for the 6502 execute unit.
// ----------------------------------------------------------------------------
package m65_pkg;

  // decoded operation codes
  typedef enum logic [5:0] {
    OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,  OP_STA = 6'd3,
    OP_STX = 6'd4,  OP_STY = 6'd5,  OP_TAX = 6'd6,  OP_TAY = 6'd7,
    OP_TXA = 6'd8,  OP_TYA = 6'd9,  OP_TSX = 6'd10, OP_TXS = 6'd11,
    OP_PHA = 6'd12, OP_PHP = 6'd13, OP_PLA = 6'd14, OP_PLP = 6'd15,
    OP_ADC = 6'd16, OP_SBC = 6'd17, OP_CMP = 6'd18, OP_CPX = 6'd19,
    OP_CPY = 6'd20, OP_AND = 6'd21, OP_EOR = 6'd22, OP_ORA = 6'd23,
    OP_BIT = 6'd24, OP_INC = 6'd25, OP_INX = 6'd26, OP_INY = 6'd27,
    OP_DEC = 6'd28, OP_DEX = 6'd29, OP_DEY = 6'd30, OP_ASL = 6'd31,
    OP_LSR = 6'd32, OP_ROL = 6'd33, OP_ROR = 6'd34, OP_BCC = 6'd35,
    OP_BCS = 6'd36, OP_BNE = 6'd37, OP_BEQ = 6'd38, OP_BPL = 6'd39,
    OP_BMI = 6'd40, OP_BVC = 6'd41, OP_BVS = 6'd42, OP_CLC = 6'd43,
    OP_CLD = 6'd44, OP_CLI = 6'd45, OP_CLV = 6'd46, OP_SEC = 6'd47,
    OP_SED = 6'd48, OP_SEI = 6'd49, OP_BRK = 6'd50, OP_NOP = 6'd51
  } op_t;

  // status bit positions
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_I = 2;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_B = 4;
  localparam int unsigned FL_U = 5;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_N = 7;

  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [7:0] FLAGS_RESET = 8'h24;

  // one input beat
  typedef struct packed {
    logic [5:0] op;
    logic [7:0] operand;
    logic       to_memory;
  } req_t;

  // one result beat
  typedef struct packed {
    logic       write_enable;
    logic [7:0] write_data;
    logic [8:0] stack_address;
    logic       branch_taken;
    logic       halted_out;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] sp_out;
    logic [7:0] flags_out;
  } rsp_t;

  // architectural register file
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] flags;
    logic       halt;
  } arch_t;

endpackage

### design/m65_alu.sv
// ----------------------------------------------------------------------------
// m65_alu
// Combinational execute logic: computes the next register file and the
// result fields of one operation from the current register file.
// ----------------------------------------------------------------------------
module m65_alu (
  input  m65_pkg::req_t  req,
  input  m65_pkg::arch_t cur,
  output m65_pkg::arch_t nxt,
  output m65_pkg::rsp_t  rsp
);
  import m65_pkg::*;

  // zero and negative from a result byte
  function automatic logic [7:0] set_zn(input logic [7:0] f, input logic [7:0] val);
    logic [7:0] r;
    r       = f;
    r[FL_Z] = (val == 8'h00);
    r[FL_N] = val[7];
    return r;
  endfunction

  logic [7:0] v;
  logic [7:0] addend;
  logic [8:0] sum;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic [7:0] sh_src;
  logic [7:0] sh_res;
  logic       sh_cout;
  logic [7:0] inc_val;
  logic [7:0] dec_val;
  logic       we;
  logic [7:0] wd;
  logic [8:0] saddr;
  logic       taken;

  assign v = req.operand;

  // adder shared by adc and sbc
  assign addend = (req.op == OP_SBC) ? ~v : v;
  assign sum    = {1'b0, cur.acc} + {1'b0, addend} + {8'h00, cur.flags[FL_C]};

  // subtractor for compares
  always_comb begin
    case (req.op)
      OP_CPX:  cmp_reg = cur.x;
      OP_CPY:  cmp_reg = cur.y;
      default: cmp_reg = cur.acc;
    endcase
  end
  assign diff = {1'b0, cmp_reg} - {1'b0, v};

  // shifter
  assign sh_src = req.to_memory ? v : cur.acc;
  always_comb begin
    case (req.op)
      OP_ASL: begin
        sh_res  = {sh_src[6:0], 1'b0};
        sh_cout = sh_src[7];
      end
      OP_ROL: begin
        sh_res  = {sh_src[6:0], cur.flags[FL_C]};
        sh_cout = sh_src[7];
      end
      OP_ROR: begin
        sh_res  = {cur.flags[FL_C], sh_src[7:1]};
        sh_cout = sh_src[0];
      end
      default: begin
        sh_res  = {1'b0, sh_src[7:1]};
        sh_cout = sh_src[0];
      end
    endcase
  end

  assign inc_val = v + 8'd1;
  assign dec_val = v - 8'd1;

  // operation decode
  always_comb begin
    nxt   = cur;
    we    = 1'b0;
    wd    = 8'h00;
    saddr = {1'b1, cur.sp};
    taken = 1'b0;
    case (req.op)
      OP_LDA: begin nxt.acc = v; nxt.flags = set_zn(cur.flags, v); end
      OP_LDX: begin nxt.x = v; nxt.flags = set_zn(cur.flags, v); end
      OP_LDY: begin nxt.y = v; nxt.flags = set_zn(cur.flags, v); end
      OP_STA: begin we = 1'b1; wd = cur.acc; end
      OP_STX: begin we = 1'b1; wd = cur.x; end
      OP_STY: begin we = 1'b1; wd = cur.y; end
      OP_TAX: begin nxt.x = cur.acc; nxt.flags = set_zn(cur.flags, cur.acc); end
      OP_TAY: begin nxt.y = cur.acc; nxt.flags = set_zn(cur.flags, cur.acc); end
      OP_TXA: begin nxt.acc = cur.x; nxt.flags = set_zn(cur.flags, cur.x); end
      OP_TYA: begin nxt.acc = cur.y; nxt.flags = set_zn(cur.flags, cur.y); end
      OP_TSX: begin nxt.x = cur.sp; nxt.flags = set_zn(cur.flags, cur.sp); end
      OP_TXS: nxt.sp = cur.x;
      OP_PHA: begin
        we     = 1'b1;
        wd     = cur.acc;
        nxt.sp = cur.sp - 8'd1;
      end
      OP_PHP: begin
        we        = 1'b1;
        wd        = cur.flags;
        wd[FL_B]  = 1'b1;
        wd[FL_U]  = 1'b1;
        nxt.sp    = cur.sp - 8'd1;
      end
      OP_PLA: begin
        nxt.sp    = cur.sp + 8'd1;
        saddr     = {1'b1, nxt.sp};
        nxt.acc   = v;
        nxt.flags = set_zn(cur.flags, v);
      end
      OP_PLP: begin
        nxt.sp          = cur.sp + 8'd1;
        saddr           = {1'b1, nxt.sp};
        nxt.flags       = v;
        nxt.flags[FL_B] = 1'b0;
        nxt.flags[FL_U] = 1'b1;
      end
      OP_ADC, OP_SBC: begin
        nxt.acc         = sum[7:0];
        nxt.flags       = set_zn(cur.flags, sum[7:0]);
        nxt.flags[FL_C] = sum[8];
        nxt.flags[FL_V] = (addend[7] ^ sum[7]) & (sum[7] ^ cur.acc[7]);
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        nxt.flags       = set_zn(cur.flags, diff[7:0]);
        nxt.flags[FL_C] = ~diff[8];
      end
      OP_AND: begin
        nxt.acc   = cur.acc & v;
        nxt.flags = set_zn(cur.flags, cur.acc & v);
      end
      OP_EOR: begin
        nxt.acc   = cur.acc ^ v;
        nxt.flags = set_zn(cur.flags, cur.acc ^ v);
      end
      OP_ORA: begin
        nxt.acc   = cur.acc | v;
        nxt.flags = set_zn(cur.flags, cur.acc | v);
      end
      OP_BIT: begin
        nxt.flags[FL_Z] = ((cur.acc & v) == 8'h00);
        nxt.flags[FL_N] = v[7];
        nxt.flags[FL_V] = v[6];
      end
      OP_INC: begin we = 1'b1; wd = inc_val; nxt.flags = set_zn(cur.flags, inc_val); end
      OP_DEC: begin we = 1'b1; wd = dec_val; nxt.flags = set_zn(cur.flags, dec_val); end
      OP_INX: begin
        nxt.x     = cur.x + 8'd1;
        nxt.flags = set_zn(cur.flags, nxt.x);
      end
      OP_INY: begin
        nxt.y     = cur.y + 8'd1;
        nxt.flags = set_zn(cur.flags, nxt.y);
      end
      OP_DEX: begin
        nxt.x     = cur.x - 8'd1;
        nxt.flags = set_zn(cur.flags, nxt.x);
      end
      OP_DEY: begin
        nxt.y     = cur.y - 8'd1;
        nxt.flags = set_zn(cur.flags, nxt.y);
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        nxt.flags       = set_zn(cur.flags, sh_res);
        nxt.flags[FL_C] = sh_cout;
        if (req.to_memory) begin
          we = 1'b1;
          wd = sh_res;
        end else begin
          nxt.acc = sh_res;
        end
      end
      OP_BCC: taken = ~cur.flags[FL_C];
      OP_BCS: taken =  cur.flags[FL_C];
      OP_BNE: taken = ~cur.flags[FL_Z];
      OP_BEQ: taken =  cur.flags[FL_Z];
      OP_BPL: taken = ~cur.flags[FL_N];
      OP_BMI: taken =  cur.flags[FL_N];
      OP_BVC: taken = ~cur.flags[FL_V];
      OP_BVS: taken =  cur.flags[FL_V];
      OP_CLC: nxt.flags[FL_C] = 1'b0;
      OP_CLD: nxt.flags[FL_D] = 1'b0;
      OP_CLI: nxt.flags[FL_I] = 1'b0;
      OP_CLV: nxt.flags[FL_V] = 1'b0;
      OP_SEC: nxt.flags[FL_C] = 1'b1;
      OP_SED: nxt.flags[FL_D] = 1'b1;
      OP_SEI: nxt.flags[FL_I] = 1'b1;
      OP_BRK: nxt.halt = 1'b1;
      default: ;
    endcase
  end

  // result fields from the updated registers
  always_comb begin
    rsp.write_enable  = we;
    rsp.write_data    = wd;
    rsp.stack_address = saddr;
    rsp.branch_taken  = taken;
    rsp.halted_out    = nxt.halt;
    rsp.acc_out       = nxt.acc;
    rsp.x_out         = nxt.x;
    rsp.y_out         = nxt.y;
    rsp.sp_out        = nxt.sp;
    rsp.flags_out     = nxt.flags;
  end

endmodule

### design/m65_regs.sv
// ----------------------------------------------------------------------------
// m65_regs
// Architectural registers A, X, Y, SP, status and halt mark; loaded with
// the execute result each time an operation retires.
// ----------------------------------------------------------------------------
module m65_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  m65_pkg::arch_t nxt,
  output m65_pkg::arch_t cur
);
  import m65_pkg::*;

  arch_t state;

  // register file update
  always_ff @(posedge clk) begin
    if (rst) begin
      state.acc   <= 8'h00;
      state.x     <= 8'h00;
      state.y     <= 8'h00;
      state.sp    <= SP_RESET;
      state.flags <= FLAGS_RESET;
      state.halt  <= 1'b0;
    end else if (load) begin
      state <= nxt;
    end
  end

  assign cur = state;

endmodule

### design/mos6502_execute_unit.sv
// ----------------------------------------------------------------------------
// mos6502_execute_unit
// Execute stage of a binary-only 6502: ALU, register file and status flags.
// ----------------------------------------------------------------------------
// Each operation beat is captured in an input register, executed in one pass
// of combinational logic against the current register file and retired into
// the result register once that register is empty or being drained.
// Throughput is one operation per cycle while the receiver takes results.
// The register file is updated at retire time, so back-to-back operations
// always see the effects of their predecessors. BRK only sets a sticky halt
// mark; later operations still execute. Decimal mode is stored but ignored.
// ----------------------------------------------------------------------------
module mos6502_execute_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  m65_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output m65_pkg::rsp_t rsp
);
  import m65_pkg::*;

  req_t  op_q;
  logic  op_valid;
  rsp_t  rsp_q;
  logic  rsp_q_valid;
  arch_t cur;
  arch_t nxt;
  rsp_t  rsp_next;
  logic  retire;

  // retire when the result register is empty or being drained
  assign retire    = op_valid & (~rsp_q_valid | rsp_ready);
  assign req_ready = ~op_valid | retire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (req_ready) begin
      op_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      op_q <= req;
    end
  end

  // execute logic
  m65_alu u_alu (
    .req (op_q),
    .cur (cur),
    .nxt (nxt),
    .rsp (rsp_next)
  );

  m65_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .load (retire),
    .nxt  (nxt),
    .cur  (cur)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_q_valid <= 1'b0;
    end else if (retire) begin
      rsp_q_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp_valid = rsp_q_valid;
  assign rsp       = rsp_q;

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 6502 execute unit. Operation beats go through
// a bursty sender, and result beats come back through a receiver that stalls.
// A cycle-free model of the register file predicts every result. A short
// directed run covers the flag and stack corner cases, and a long random
// program follows it.
// ----------------------------------------------------------------------------
module testbench;
  import m65_pkg::*;

  // codes with no operation behind them execute as nop
  localparam logic [5:0] OP_UNUSED_LO = 6'd52;
  localparam logic [5:0] OP_UNUSED_HI = 6'd63;
  localparam int RANDOM_BEATS = 1250;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;

  arch_t cpu;
  rsp_t  expected_rsp[$];
  rsp_t  predicted;
  rsp_t  want_rsp;
  int    errors = 0;
  int    burst_left = 0;
  int    stall_mode = 0;
  int    stall_left = 0;
  int    tick = 0;
  int    idle_cycles = 0;

  mos6502_execute_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // set z and n from a result byte
  function automatic logic [7:0] with_nz(input logic [7:0] v);
    cpu.flags[FL_Z] = (v == 8'h00);
    cpu.flags[FL_N] = v[7];
    return v;
  endfunction

  // binary add with carry into the accumulator
  function automatic void add_to_acc(input logic [7:0] v);
    logic [8:0] sum;
    logic [7:0] r;
    sum = {1'b0, cpu.acc} + {1'b0, v} + {8'h00, cpu.flags[FL_C]};
    r = sum[7:0];
    cpu.flags[FL_C] = sum[8];
    cpu.flags[FL_V] = ((v ^ r) & (r ^ cpu.acc) & 8'h80) != 8'h00;
    cpu.acc = with_nz(r);
  endfunction

  function automatic void compare_reg(input logic [7:0] reg_val, input logic [7:0] v);
    cpu.flags[FL_C] = (v <= reg_val);
    void'(with_nz(reg_val - v));
  endfunction

  // one step of the execute unit against the modeled register file
  task automatic execute_model(input req_t item, output rsp_t res);
    logic [7:0] v;
    logic [7:0] r;
    logic [7:0] src;
    logic       cin;
    v = item.operand;
    res = '0;
    res.stack_address = {1'b1, cpu.sp};
    case (item.op)
      OP_LDA: cpu.acc = with_nz(v);
      OP_LDX: cpu.x = with_nz(v);
      OP_LDY: cpu.y = with_nz(v);
      OP_STA: begin res.write_enable = 1'b1; res.write_data = cpu.acc; end
      OP_STX: begin res.write_enable = 1'b1; res.write_data = cpu.x; end
      OP_STY: begin res.write_enable = 1'b1; res.write_data = cpu.y; end
      OP_TAX: cpu.x = with_nz(cpu.acc);
      OP_TAY: cpu.y = with_nz(cpu.acc);
      OP_TXA: cpu.acc = with_nz(cpu.x);
      OP_TYA: cpu.acc = with_nz(cpu.y);
      OP_TSX: cpu.x = with_nz(cpu.sp);
      OP_TXS: cpu.sp = cpu.x;
      OP_PHA, OP_PHP: begin
        res.write_enable = 1'b1;
        if (item.op == OP_PHA) begin
          res.write_data = cpu.acc;
        end else begin
          res.write_data = cpu.flags;
          res.write_data[FL_B] = 1'b1;
          res.write_data[FL_U] = 1'b1;
        end
        cpu.sp = cpu.sp - 8'd1;
      end
      OP_PLA, OP_PLP: begin
        cpu.sp = cpu.sp + 8'd1;
        res.stack_address = {1'b1, cpu.sp};
        if (item.op == OP_PLA) begin
          cpu.acc = with_nz(v);
        end else begin
          cpu.flags = v;
          cpu.flags[FL_B] = 1'b0;
          cpu.flags[FL_U] = 1'b1;
        end
      end
      OP_ADC: add_to_acc(v);
      OP_SBC: add_to_acc(~v);
      OP_CMP: compare_reg(cpu.acc, v);
      OP_CPX: compare_reg(cpu.x, v);
      OP_CPY: compare_reg(cpu.y, v);
      OP_AND: cpu.acc = with_nz(cpu.acc & v);
      OP_EOR: cpu.acc = with_nz(cpu.acc ^ v);
      OP_ORA: cpu.acc = with_nz(cpu.acc | v);
      OP_BIT: begin
        cpu.flags[FL_Z] = ((cpu.acc & v) == 8'h00);
        cpu.flags[FL_N] = v[7];
        cpu.flags[FL_V] = v[6];
      end
      OP_INC: begin res.write_enable = 1'b1; res.write_data = with_nz(v + 8'd1); end
      OP_INX: cpu.x = with_nz(cpu.x + 8'd1);
      OP_INY: cpu.y = with_nz(cpu.y + 8'd1);
      OP_DEC: begin res.write_enable = 1'b1; res.write_data = with_nz(v - 8'd1); end
      OP_DEX: cpu.x = with_nz(cpu.x - 8'd1);
      OP_DEY: cpu.y = with_nz(cpu.y - 8'd1);
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        src = item.to_memory ? v : cpu.acc;
        cin = cpu.flags[FL_C];
        if (item.op == OP_ASL || item.op == OP_ROL) begin
          r = {src[6:0], (item.op == OP_ROL) ? cin : 1'b0};
          cpu.flags[FL_C] = src[7];
        end else begin
          r = {(item.op == OP_ROR) ? cin : 1'b0, src[7:1]};
          cpu.flags[FL_C] = src[0];
        end
        r = with_nz(r);
        if (item.to_memory) begin
          res.write_enable = 1'b1;
          res.write_data = r;
        end else begin
          cpu.acc = r;
        end
      end
      OP_BCC: res.branch_taken = !cpu.flags[FL_C];
      OP_BCS: res.branch_taken = cpu.flags[FL_C];
      OP_BNE: res.branch_taken = !cpu.flags[FL_Z];
      OP_BEQ: res.branch_taken = cpu.flags[FL_Z];
      OP_BPL: res.branch_taken = !cpu.flags[FL_N];
      OP_BMI: res.branch_taken = cpu.flags[FL_N];
      OP_BVC: res.branch_taken = !cpu.flags[FL_V];
      OP_BVS: res.branch_taken = cpu.flags[FL_V];
      OP_CLC: cpu.flags[FL_C] = 1'b0;
      OP_CLD: cpu.flags[FL_D] = 1'b0;
      OP_CLI: cpu.flags[FL_I] = 1'b0;
      OP_CLV: cpu.flags[FL_V] = 1'b0;
      OP_SEC: cpu.flags[FL_C] = 1'b1;
      OP_SED: cpu.flags[FL_D] = 1'b1;
      OP_SEI: cpu.flags[FL_I] = 1'b1;
      OP_BRK: cpu.halt = 1'b1;
      default: ;
    endcase
    res.halted_out = cpu.halt;
    res.acc_out    = cpu.acc;
    res.x_out      = cpu.x;
    res.y_out      = cpu.y;
    res.sp_out     = cpu.sp;
    res.flags_out  = cpu.flags;
  endtask

  // send one operation beat; the sender may idle between bursts
  task automatic send_beat(input logic [5:0] op, input logic [7:0] operand,
                           input logic mem);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= '{op: op, operand: operand, to_memory: mem};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // predict each accepted operation beat
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      execute_model(req, predicted);
      expected_rsp.push_back(predicted);
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: result beat expected none actual %h", $time, rsp);
        errors++;
      end else begin
        want_rsp = expected_rsp.pop_front();
        check_field("write_enable", int'(want_rsp.write_enable), int'(rsp.write_enable));
        check_field("write_data", int'(want_rsp.write_data), int'(rsp.write_data));
        check_field("stack_address", int'(want_rsp.stack_address),
                    int'(rsp.stack_address));
        check_field("branch_taken", int'(want_rsp.branch_taken), int'(rsp.branch_taken));
        check_field("halted_out", int'(want_rsp.halted_out), int'(rsp.halted_out));
        check_field("acc_out", int'(want_rsp.acc_out), int'(rsp.acc_out));
        check_field("x_out", int'(want_rsp.x_out), int'(rsp.x_out));
        check_field("y_out", int'(want_rsp.y_out), int'(rsp.y_out));
        check_field("sp_out", int'(want_rsp.sp_out), int'(rsp.sp_out));
        check_field("flags_out", int'(want_rsp.flags_out), int'(rsp.flags_out));
      end
    end
  end

  // receiver backpressure: always ready, coin flip, ready when tick is a multiple of three, mostly ready
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    tick++;
    case (stall_mode)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= ($urandom_range(0, 1) == 1);
      2: rsp_ready <= (tick % 3 == 0);
      default: rsp_ready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[mos6502_execute_unit] ERROR");
      $finish;
    end
  end

  task automatic test_loads_and_stores();
    send_beat(OP_LDA, 8'h00, 1'b0);
    send_beat(OP_LDA, 8'h80, 1'b1);
    send_beat(OP_LDX, 8'hFF, 1'b0);
    // to_memory has no meaning for a store
    send_beat(OP_STA, 8'h5A, 1'b1);
    send_beat(OP_STY, 8'hFF, 1'b0);
  endtask

  // pushes and pulls across the page-one wrap, status byte bits b and u
  task automatic test_stack_wrap();
    send_beat(OP_LDX, 8'h00, 1'b0);
    send_beat(OP_TXS, 8'h00, 1'b0);
    send_beat(OP_PHP, 8'h00, 1'b0);
    send_beat(OP_PLP, 8'hFF, 1'b0);
    send_beat(OP_PHA, 8'h00, 1'b0);
    send_beat(OP_PLA, 8'h00, 1'b0);
  endtask

  // decimal flag set but arithmetic stays binary
  task automatic test_arithmetic();
    send_beat(OP_SED, 8'h00, 1'b0);
    send_beat(OP_LDA, 8'h7F, 1'b0);
    send_beat(OP_ADC, 8'h01, 1'b0);
    send_beat(OP_SBC, 8'hFF, 1'b0);
    send_beat(OP_CMP, 8'h80, 1'b0);
  endtask

  // bit takes v from operand bit 6, memory read-modify-write forms
  task automatic test_bit_and_memory_ops();
    send_beat(OP_BIT, 8'hC0, 1'b0);
    send_beat(OP_BIT, 8'h40, 1'b0);
    send_beat(OP_ROR, 8'h01, 1'b1);
    send_beat(OP_INC, 8'hFF, 1'b0);
    send_beat(OP_DEC, 8'h00, 1'b1);
  endtask

  task automatic test_branches();
    send_beat(OP_SEC, 8'h00, 1'b0);
    send_beat(OP_BCS, 8'h00, 1'b0);
    send_beat(OP_BVC, 8'hFF, 1'b1);
  endtask

  // unused codes act as nop, brk only sets the sticky halt mark
  task automatic test_halt_and_unused();
    send_beat(OP_UNUSED_HI, 8'hFF, 1'b1);
    send_beat(OP_BRK, 8'h00, 1'b0);
    send_beat(OP_LDA, 8'h55, 1'b0);
  endtask

  task automatic test_random_program();
    logic [5:0] op;
    logic [7:0] operand;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if ($urandom_range(0, 99) < 6) begin
        op = 6'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else begin
        op = 6'($urandom_range(0, OP_UNUSED_LO - 1));
      end
      // lean on the boundary bytes that drive carry and overflow
      case ($urandom_range(0, 7))
        0: operand = 8'h00;
        1: operand = 8'hFF;
        2: operand = 8'h80;
        3: operand = 8'h7F;
        default: operand = 8'($urandom_range(0, 255));
      endcase
      send_beat(op, operand, 1'($urandom_range(0, 1)));
    end
  endtask

  // test sequence
  initial begin
    cpu = '0;
    cpu.sp = SP_RESET;
    cpu.flags = FLAGS_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_loads_and_stores();
    test_stack_wrap();
    test_arithmetic();
    test_bit_and_memory_ops();
    test_branches();
    test_halt_and_unused();
    test_random_program();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[mos6502_execute_unit] OK");
    end else begin
      $display("[mos6502_execute_unit] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
design/m65_pkg.sv
design/m65_alu.sv
design/m65_regs.sv
design/mos6502_execute_unit.sv
test/testbench.sv
